// ===== rtl/bkrd_pkg.sv =====
// Shared constants and types of the boot keyboard report differ.
package bkrd_pkg;

	localparam int KEY_SLOTS = 6;
	localparam int MOD_BITS = 8;
	localparam int EVENTS = MOD_BITS + 2 * KEY_SLOTS;
	localparam int REL_BASE = MOD_BITS;
	localparam int PRS_BASE = MOD_BITS + KEY_SLOTS;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int LEN_W = 4;
	localparam int SLOTPOS_W = $clog2(KEY_SLOTS + 3);

	localparam logic [7:0] MOD_USAGE_BASE = 8'hE0;
	localparam logic [7:0] ERROR_ROLLOVER = 8'h01;
	localparam logic [7:0] KEY_EMPTY = 8'h00;

	typedef logic [7:0] usage_t;
	typedef usage_t [KEY_SLOTS-1:0] key_row_t;

	// One classified report: pending events and the bytes their usages come from.
	typedef struct packed {
		logic [EVENTS-1:0] mask;
		logic [MOD_BITS-1:0] mods;
		key_row_t cur_keys;
		key_row_t prev_keys;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

// ===== rtl/bkrd_front.sv =====
// Front part: accepts reports, diffs them against the kept report, queues jobs.
module bkrd_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [bkrd_pkg::LEN_W-1:0]    report_length,
	input  logic [bkrd_pkg::MOD_BITS-1:0] modifier_bits,
	input  bkrd_pkg::key_row_t            key_slots,
	output logic                          push,
	output bkrd_pkg::job_t                job
);

	logic [bkrd_pkg::MOD_BITS-1:0] prev_mods_q;
	bkrd_pkg::key_row_t prev_keys_q;
	bkrd_pkg::key_row_t cur_keys;
	logic [bkrd_pkg::KEY_SLOTS-1:0] rel_mask;
	logic [bkrd_pkg::KEY_SLOTS-1:0] prs_mask;
	logic [bkrd_pkg::KEY_SLOTS-1:0] in_cur;
	logic [bkrd_pkg::KEY_SLOTS-1:0] in_prev;
	logic report_live;

	assign report_live = (report_length != '0);

	always_comb begin
		for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
			// Slot i is report byte i+2; bytes at or past the length read as zero.
			if (bkrd_pkg::SLOTPOS_W'(i + 2) <
			    bkrd_pkg::SLOTPOS_W'(report_length)) begin
				cur_keys[i] = key_slots[i];
			end else begin
				cur_keys[i] = bkrd_pkg::KEY_EMPTY;
			end
		end
		for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
			in_cur[i] = 1'b0;
			in_prev[i] = 1'b0;
			for (int j = 0; j < bkrd_pkg::KEY_SLOTS; j++) begin
				if (cur_keys[j] == prev_keys_q[i]) begin
					in_cur[i] = 1'b1;
				end
				if (prev_keys_q[j] == cur_keys[i]) begin
					in_prev[i] = 1'b1;
				end
			end
			rel_mask[i] = (prev_keys_q[i] != bkrd_pkg::KEY_EMPTY) && !in_cur[i];
			prs_mask[i] = (cur_keys[i] != bkrd_pkg::KEY_EMPTY) &&
			              (cur_keys[i] != bkrd_pkg::ERROR_ROLLOVER) && !in_prev[i];
		end
	end

	assign job.mask = {prs_mask, rel_mask, modifier_bits ^ prev_mods_q};
	assign job.mods = modifier_bits;
	assign job.cur_keys = cur_keys;
	assign job.prev_keys = prev_keys_q;
	assign push = accept && report_live && (job.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (accept && report_live) begin
			prev_mods_q <= modifier_bits;
			prev_keys_q <= cur_keys;
		end
	end

endmodule

// ===== rtl/bkrd_queue.sv =====
// Short job queue between the front and back parts.
module bkrd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bkrd_pkg::job_t        push_job,
	input  logic                  pop,
	output bkrd_pkg::job_t        head_job,
	output bkrd_pkg::queue_stat_t stat
);

	bkrd_pkg::job_t entry_q [bkrd_pkg::QUEUE_DEPTH];
	logic [bkrd_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [bkrd_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [bkrd_pkg::QCNT_W-1:0] count_q;

	assign stat.full = (count_q == bkrd_pkg::QCNT_W'(bkrd_pkg::QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign head_job = entry_q[rd_ptr_q];

	function automatic logic [bkrd_pkg::QPTR_W-1:0] next_ptr(
		input logic [bkrd_pkg::QPTR_W-1:0] ptr);
		if (ptr == bkrd_pkg::QPTR_W'(bkrd_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bkrd_back.sv =====
// Back part: walks a job's pending events in order and emits one per cycle while the output is not stalled.
module bkrd_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bkrd_pkg::job_t        head_job,
	input  logic                  q_empty,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            key_usage,
	output logic                  is_press,
	output logic                  last_event
);

	bkrd_pkg::job_t job_q;
	logic job_valid_q;
	logic out_valid_q;
	logic [7:0] usage_q;
	logic press_q;
	logic last_q;
	logic [bkrd_pkg::EVENTS-1:0] sel;
	logic [bkrd_pkg::EVENTS-1:0] rest;
	logic emit;
	logic [7:0] sel_usage;
	logic sel_press;

	// Lowest pending event goes first: modifiers, then releases, then presses.
	assign sel = job_q.mask & (~job_q.mask + 1'b1);
	assign rest = job_q.mask & ~sel;
	assign emit = job_valid_q && (!out_valid_q || !out_stall);
	assign pop = !q_empty && (!job_valid_q || (emit && (rest == '0)));

	always_comb begin
		sel_usage = '0;
		sel_press = 1'b0;
		for (int i = 0; i < bkrd_pkg::MOD_BITS; i++) begin
			if (sel[i]) begin
				sel_usage = sel_usage | (bkrd_pkg::MOD_USAGE_BASE + 8'(i));
				sel_press = sel_press | job_q.mods[i];
			end
		end
		for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
			if (sel[bkrd_pkg::REL_BASE + i]) begin
				sel_usage = sel_usage | job_q.prev_keys[i];
			end
			if (sel[bkrd_pkg::PRS_BASE + i]) begin
				sel_usage = sel_usage | job_q.cur_keys[i];
				sel_press = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head_job;
		end else if (emit) begin
			job_q.mask <= rest;
		end
		if (emit) begin
			usage_q <= sel_usage;
			press_q <= sel_press;
			last_q <= (rest == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				job_valid_q <= 1'b1;
			end else if (emit && (rest == '0)) begin
				job_valid_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign key_usage = usage_q;
	assign is_press = press_q;
	assign last_event = last_q;

endmodule

// ===== rtl/boot_keyboard_report_differ_unit.sv =====
// Top level of the boot keyboard report differ.
//
// The input channel takes one boot keyboard report per item: its valid length,
// the modifier byte and six key slots. The output channel gives one key event
// per item: the usage, make or break, and a flag on the last event of a report.
// Events come in a fixed order: modifier changes for bits 0 to 7 as usages
// 0xE0 upward, then releases in previous slot order, then presses in current
// slot order. A report of length zero is taken and gives nothing.
// The front part diffs a report in the cycle it is accepted and, if it gives any
// events, writes one job into a two-entry queue. The back part emits one event
// per cycle while the output is not stalled; a report gives at most 20 events.
// The first event of a report passes the queue entry, the job register and the
// output register on its way out. in_stall rises only while the queue is full.
// Reset clears the kept report to zeros and empties the queue and output.
// When the receiver stalls, the event in the output register holds and the
// back part waits; the front keeps taking reports until the queue fills.
module boot_keyboard_report_differ_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bkrd_pkg::LEN_W-1:0]    report_length,
	input  logic [bkrd_pkg::MOD_BITS-1:0] modifier_bits,
	input  logic [7:0]                    key_slot_0,
	input  logic [7:0]                    key_slot_1,
	input  logic [7:0]                    key_slot_2,
	input  logic [7:0]                    key_slot_3,
	input  logic [7:0]                    key_slot_4,
	input  logic [7:0]                    key_slot_5,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    key_usage,
	output logic                          is_press,
	output logic                          last_event
);

	bkrd_pkg::key_row_t key_slots;
	bkrd_pkg::job_t front_job;
	bkrd_pkg::job_t head_job;
	bkrd_pkg::queue_stat_t q_stat;
	logic in_accept;
	logic q_push;
	logic q_pop;

	assign key_slots = {key_slot_5, key_slot_4, key_slot_3,
	                    key_slot_2, key_slot_1, key_slot_0};
	assign in_stall = q_stat.full;
	assign in_accept = in_valid && !in_stall;

	bkrd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (in_accept),
		.report_length (report_length),
		.modifier_bits (modifier_bits),
		.key_slots     (key_slots),
		.push          (q_push),
		.job           (front_job)
	);

	bkrd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (front_job),
		.pop      (q_pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	bkrd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_job   (head_job),
		.q_empty    (q_stat.empty),
		.pop        (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_usage  (key_usage),
		.is_press   (is_press),
		.last_event (last_event)
	);

	// The queue never takes a job while full nor gives one while empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && q_stat.empty))
		else $error("job queue underflow");

	// A report of length zero never reaches the back part.
	a_zero_len_no_job: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && (report_length == '0)) |-> !q_push)
		else $error("zero length report queued a job");

endmodule

// ===== test/boot_keyboard_report_differ_unit_tb.sv =====
// Self-checking testbench for the boot keyboard report differ.
`timescale 1ns / 1ps

module boot_keyboard_report_differ_unit_tb;

	localparam int REPORT_BYTES = bkrd_pkg::KEY_SLOTS + 2;
	localparam int TAIL_CYCLES = 60;

	typedef struct {
		logic [bkrd_pkg::LEN_W-1:0] len;
		logic [bkrd_pkg::MOD_BITS-1:0] mods;
		bkrd_pkg::key_row_t keys;
	} report_t;

	typedef struct {
		logic [7:0] usage;
		logic press;
		logic last;
	} key_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [bkrd_pkg::LEN_W-1:0] report_length = '0;
	logic [bkrd_pkg::MOD_BITS-1:0] modifier_bits = '0;
	logic [7:0] key_slot_0 = '0;
	logic [7:0] key_slot_1 = '0;
	logic [7:0] key_slot_2 = '0;
	logic [7:0] key_slot_3 = '0;
	logic [7:0] key_slot_4 = '0;
	logic [7:0] key_slot_5 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] key_usage;
	logic is_press;
	logic last_event;

	report_t pending_reports[$];
	key_event_t expected_events[$];
	report_t driven_report;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	int error_count = 0;

	// Report as the block last stored it.
	logic [bkrd_pkg::MOD_BITS-1:0] held_mods = '0;
	bkrd_pkg::key_row_t held_keys = '0;

	boot_keyboard_report_differ_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.report_length(report_length),
		.modifier_bits(modifier_bits),
		.key_slot_0(key_slot_0),
		.key_slot_1(key_slot_1),
		.key_slot_2(key_slot_2),
		.key_slot_3(key_slot_3),
		.key_slot_4(key_slot_4),
		.key_slot_5(key_slot_5),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_usage(key_usage),
		.is_press(is_press),
		.last_event(last_event)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic bit row_holds(input bkrd_pkg::key_row_t row, input logic [7:0] usage);
		for (int j = 0; j < bkrd_pkg::KEY_SLOTS; j++) begin
			if (row[j] == usage) return 1'b1;
		end
		return 1'b0;
	endfunction

	// Diffs one report against the held one and queues the key events it causes.
	task automatic predict_key_events(input report_t r);
		int len;
		logic [bkrd_pkg::MOD_BITS-1:0] changed;
		bkrd_pkg::key_row_t now_keys;
		key_event_t batch[$];
		key_event_t ev;
		len = r.len;
		if (len == 0) return;
		if (len > REPORT_BYTES) len = REPORT_BYTES;
		for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
			now_keys[i] = (i + 2 < len) ? r.keys[i] : bkrd_pkg::KEY_EMPTY;
		end
		changed = r.mods ^ held_mods;
		for (int i = 0; i < bkrd_pkg::MOD_BITS; i++) begin
			if (changed[i]) begin
				ev.usage = bkrd_pkg::MOD_USAGE_BASE + 8'(i);
				ev.press = r.mods[i];
				ev.last = 1'b0;
				batch.push_back(ev);
			end
		end
		for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
			if (held_keys[i] != bkrd_pkg::KEY_EMPTY &&
					!row_holds(now_keys, held_keys[i])) begin
				ev.usage = held_keys[i];
				ev.press = 1'b0;
				ev.last = 1'b0;
				batch.push_back(ev);
			end
		end
		for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
			if (now_keys[i] != bkrd_pkg::KEY_EMPTY &&
					now_keys[i] != bkrd_pkg::ERROR_ROLLOVER &&
					!row_holds(held_keys, now_keys[i])) begin
				ev.usage = now_keys[i];
				ev.press = 1'b1;
				ev.last = 1'b0;
				batch.push_back(ev);
			end
		end
		if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
		foreach (batch[k]) expected_events.push_back(batch[k]);
		held_mods = r.mods;
		held_keys = now_keys;
	endtask

	// Sender: a new item is offered only when the channel is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			report_length <= '0;
			modifier_bits <= '0;
			key_slot_0 <= '0;
			key_slot_1 <= '0;
			key_slot_2 <= '0;
			key_slot_3 <= '0;
			key_slot_4 <= '0;
			key_slot_5 <= '0;
		end else begin
			if (in_valid && !in_stall) predict_key_events(driven_report);
			if (!in_valid || !in_stall) begin
				if (pending_reports.size() > 0 &&
						$urandom_range(99) >= sender_idle_pct) begin
					driven_report = pending_reports.pop_front();
					in_valid <= 1'b1;
					report_length <= driven_report.len;
					modifier_bits <= driven_report.mods;
					key_slot_0 <= driven_report.keys[0];
					key_slot_1 <= driven_report.keys[1];
					key_slot_2 <= driven_report.keys[2];
					key_slot_3 <= driven_report.keys[3];
					key_slot_4 <= driven_report.keys[4];
					key_slot_5 <= driven_report.keys[5];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each accepted event against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		key_event_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					flag_error($sformatf("unexpected event usage %02h press %b last %b",
						key_usage, is_press, last_event));
				end else begin
					want = expected_events.pop_front();
					if (key_usage !== want.usage)
						flag_error($sformatf("key_usage %02h, expected %02h",
							key_usage, want.usage));
					if (is_press !== want.press)
						flag_error($sformatf("is_press %b, expected %b for usage %02h",
							is_press, want.press, want.usage));
					if (last_event !== want.last)
						flag_error($sformatf("last_event %b, expected %b for usage %02h",
							last_event, want.last, want.usage));
				end
			end
			out_stall <= ($urandom_range(99) < receiver_stall_pct);
		end
	end

	task automatic queue_report(input int len, input int mods, input int k0, input int k1,
			input int k2, input int k3, input int k4, input int k5);
		report_t r;
		r.len = bkrd_pkg::LEN_W'(len);
		r.mods = bkrd_pkg::MOD_BITS'(mods);
		r.keys[0] = 8'(k0);
		r.keys[1] = 8'(k1);
		r.keys[2] = 8'(k2);
		r.keys[3] = 8'(k3);
		r.keys[4] = 8'(k4);
		r.keys[5] = 8'(k5);
		pending_reports.push_back(r);
	endtask

	// Mostly full reports drawn from a small key pool, so that keys persist between
	// reports; the rest is noise over every field value.
	function automatic report_t random_report();
		report_t r;
		if ($urandom_range(9) == 0) begin
			r.len = bkrd_pkg::LEN_W'($urandom_range(15));
			r.mods = bkrd_pkg::MOD_BITS'($urandom);
			for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) r.keys[i] = 8'($urandom);
		end else begin
			r.len = ($urandom_range(7) == 0) ?
				bkrd_pkg::LEN_W'($urandom_range(REPORT_BYTES)) :
				bkrd_pkg::LEN_W'(REPORT_BYTES);
			r.mods = ($urandom_range(1) == 0) ? bkrd_pkg::MOD_BITS'($urandom) :
				bkrd_pkg::MOD_BITS'(1 << $urandom_range(bkrd_pkg::MOD_BITS - 1));
			for (int i = 0; i < bkrd_pkg::KEY_SLOTS; i++) begin
				case ($urandom_range(9))
					0, 1, 2: r.keys[i] = bkrd_pkg::KEY_EMPTY;
					3: r.keys[i] = bkrd_pkg::ERROR_ROLLOVER;
					9: r.keys[i] = 8'($urandom);
					default: r.keys[i] = 8'($urandom_range(12, 4));
				endcase
			end
		end
		return r;
	endfunction

	task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
		@(negedge clk);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		repeat (count) pending_reports.push_back(random_report());
		while (pending_reports.size() > 0 || in_valid) @(negedge clk);
		// The sender holds off here until every event has been taken.
		while (expected_events.size() > 0) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		queue_report(0, 'hFF, 'h04, 'h05, 'h06, 'h07, 'h08, 'h09);
		queue_report(8, 'h00, 0, 0, 0, 0, 0, 0);
		queue_report(8, 'hFF, 'h04, 'h05, 'h06, 'h07, 'h08, 'h09);
		queue_report(8, 'hFF, 'h04, 'h05, 'h06, 'h07, 'h08, 'h09);
		// Every modifier, every old key and every new key change at once.
		queue_report(8, 'h00, 'h0A, 'h0B, 'h0C, 'h0D, 'h0E, 'h0F);
		queue_report(15, 'h55, 'h0A, 'h0B, 'h0C, 'h0D, 'h0E, 'h0F);
		queue_report(5, 'h55, 'h0A, 'h0B, 'h0C, 'h0D, 'h0E, 'h0F);
		queue_report(1, 'hAA, 'h0A, 'h0B, 'h0C, 'h0D, 'h0E, 'h0F);
		queue_report(2, 'hAA, 'h11, 'h12, 'h13, 'h14, 'h15, 'h16);
		queue_report(8, 'hAA, 'h01, 'h01, 'h01, 'h01, 'h01, 'h01);
		queue_report(8, 'hAA, 'h01, 'h04, 0, 0, 0, 0);
		queue_report(8, 'hAA, 0, 0, 0, 0, 0, 0);
		queue_report(8, 'h00, 'h04, 'h04, 'h04, 0, 0, 0);
		queue_report(8, 'h00, 0, 0, 0, 0, 0, 0);
		queue_report(8, 'h80, 'hFF, 'hE0, 'hE7, 0, 0, 'h01);
		queue_report(3, 'h01, 'hFF, 'h20, 'h21, 'h22, 'h23, 'h24);
		queue_report(4, 'h01, 'hFF, 'h20, 'h21, 'h22, 'h23, 'h24);
		queue_report(6, 'h01, 'hFF, 'h20, 'h21, 'h22, 'h23, 'h24);
		queue_report(7, 'h01, 'hFF, 'h20, 'h21, 'h22, 'h23, 'h24);
		queue_report(0, 'h00, 0, 0, 0, 0, 0, 0);
		queue_report(8, 'h00, 0, 0, 0, 0, 0, 0);

		run_phase(0, 0, 100);
		run_phase(82, 0, 100);
		run_phase(0, 82, 100);
		run_phase(31, 31, 100);

		repeat (TAIL_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_events.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bkrd_pkg.sv
rtl/bkrd_front.sv
rtl/bkrd_queue.sv
rtl/bkrd_back.sv
rtl/boot_keyboard_report_differ_unit.sv
test/boot_keyboard_report_differ_unit_tb.sv
